@@ sv/tsg_pkg.sv @@
`timescale 1ns / 1ps
package tsg_pkg;

  // Fixed field widths of a draw command and of a span.
  localparam int WIDTH_W  = 7;
  localparam int HEIGHT_W = 10;
  localparam int COLOR_W  = 8;
  localparam int STEP_W   = WIDTH_W - 1;

  // Span budget per command.
  localparam int SPAN_LIMIT = 64;
  localparam int COUNT_W    = $clog2(SPAN_LIMIT + 1);

  // Restoring divider: one quotient bit per cycle.
  localparam int DIV_STEPS = HEIGHT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Shrink rules.
  localparam int WIDE_MARGIN   = 50;
  localparam int SHRINK_WIDE   = 4;
  localparam int SHRINK_NARROW = 2;

  typedef struct packed {
    logic load;      // latch a new command and start the divide
    logic div_step;  // advance the divider by one bit
    logic emit;      // load the current row into the output register and advance
  } tsg_cmd_t;

  typedef struct packed {
    logic div_done;  // this divide step produces the final quotient bit
    logic has_span;  // current row state describes a span to send
    logic last;      // the current row is the final span of the command
    logic out_free;  // output register can take a beat this cycle
  } tsg_status_t;

endpackage

@@ sv/triangle_span_generator.sv @@
`timescale 1ns / 1ps
// A latched command first runs the serial height divider; its first span is registered after the divide.
// Throughput: one span per cycle after the divide, up to 64 spans, while span_stall does not hold
// the output register; the serial height divider runs once per command before its spans.
// The next command is accepted the cycle after its predecessor's last span is registered.
// Reset (rst, synchronous, active high) returns the controller to idle and empties the
// output register; held command and row registers keep stale values until the next load.
module triangle_span_generator
  import tsg_pkg::*;
#(
  parameter int MAX_WIDTH  = 127,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  // Command channel: accepted when cmd_valid is high and cmd_stall is low.
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic [WIDTH_W-1:0]           width,
  input  logic [HEIGHT_W-1:0]          height,
  input  logic                         outline,
  input  logic [COLOR_W-1:0]           color_r,
  input  logic [COLOR_W-1:0]           color_g,
  input  logic [COLOR_W-1:0]           color_b,
  // Span channel: one beat per row, base row first.
  output logic                         span_valid,
  input  logic                         span_stall,
  output logic signed [COORD_BITS:0]   span_x,
  output logic signed [COORD_BITS:0]   span_end_x,
  output logic signed [COORD_BITS:0]   span_y,
  output logic [WIDTH_W-1:0]           span_len,
  output logic                         endpoints_only,
  output logic [COLOR_W-1:0]           out_r,
  output logic [COLOR_W-1:0]           out_g,
  output logic [COLOR_W-1:0]           out_b,
  output logic                         last_span
);

  // The controller sequences load, divide and row emission; the datapath holds the
  // command, runs the restoring divider for rows-per-step and walks the rows.
  tsg_cmd_t    cmd;
  tsg_status_t status;

  tsg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Advance a row only when the output register is empty or its beat is taken,
  // so a waiting span never blocks the walk longer than needed.
  tsg_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .width          (width),
    .height         (height),
    .outline        (outline),
    .color_r        (color_r),
    .color_g        (color_g),
    .color_b        (color_b),
    .span_stall     (span_stall),
    .span_valid     (span_valid),
    .span_x         (span_x),
    .span_end_x     (span_end_x),
    .span_y         (span_y),
    .span_len       (span_len),
    .endpoints_only (endpoints_only),
    .out_r          (out_r),
    .out_g          (out_g),
    .out_b          (out_b),
    .last_span      (last_span)
  );

endmodule

@@ sv/tsg_ctrl.sv @@
`timescale 1ns / 1ps
module tsg_ctrl
  import tsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  tsg_status_t status,
  output tsg_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign cmd_stall = (state != ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && cmd_valid;
    cmd.div_step = (state == ST_DIVIDE);
    cmd.emit     = (state == ST_EMIT) && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        // drop commands with no rows right after the divide
        if (status.div_done) state_next = status.has_span ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/tsg_dpath.sv @@
`timescale 1ns / 1ps
module tsg_dpath
  import tsg_pkg::*;
#(
  parameter int MAX_WIDTH  = 127,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tsg_cmd_t                     cmd,
  output tsg_status_t                  status,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic [WIDTH_W-1:0]           width,
  input  logic [HEIGHT_W-1:0]          height,
  input  logic                         outline,
  input  logic [COLOR_W-1:0]           color_r,
  input  logic [COLOR_W-1:0]           color_g,
  input  logic [COLOR_W-1:0]           color_b,
  input  logic                         span_stall,
  output logic                         span_valid,
  output logic signed [COORD_BITS:0]   span_x,
  output logic signed [COORD_BITS:0]   span_end_x,
  output logic signed [COORD_BITS:0]   span_y,
  output logic [WIDTH_W-1:0]           span_len,
  output logic                         endpoints_only,
  output logic [COLOR_W-1:0]           out_r,
  output logic [COLOR_W-1:0]           out_g,
  output logic [COLOR_W-1:0]           out_b,
  output logic                         last_span
);

  localparam int CW = COORD_BITS + 1;

  // Held command
  logic [COORD_BITS-1:0] base_x;
  logic [WIDTH_W-1:0]    base_w;
  logic [HEIGHT_W-1:0]   hgt;
  logic                  outl;
  logic [COLOR_W-1:0]    col_r;
  logic [COLOR_W-1:0]    col_g;
  logic [COLOR_W-1:0]    col_b;
  logic                  wide;
  logic                  shrink4;

  // Row walk
  logic [WIDTH_W-1:0]    row_width;
  logic [CW-1:0]         row_y;
  logic [COUNT_W-1:0]    row_cnt;
  logic [HEIGHT_W-1:0]   step_cnt;

  // Divider
  logic [STEP_W-1:0]     divisor;
  logic [STEP_W-1:0]     rem;
  logic [HEIGHT_W-1:0]   quo;
  logic [DIV_CNT_W-1:0]  div_cnt;

  logic [WIDTH_W-1:0]    w_sat;
  logic [STEP_W-1:0]     half_w;
  logic [STEP_W:0]       trial;
  logic [STEP_W:0]       diff;
  logic                  ge;
  logic [HEIGHT_W-1:0]   rows_per_step;
  logic [HEIGHT_W:0]     step_inc;
  logic                  dec_now;
  logic [WIDTH_W-1:0]    dec_amt;
  logic [WIDTH_W-1:0]    width_next;
  logic                  width_pos_next;
  logic [COUNT_W-1:0]    cnt_inc;
  logic                  has_span;
  logic                  next_has;
  logic [WIDTH_W-1:0]    w_diff;
  logic [CW-1:0]         xs;
  logic [CW-1:0]         xe;

  assign w_sat  = (width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width;
  assign half_w = w_sat[WIDTH_W-1:1];

  assign trial = {rem, quo[HEIGHT_W-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  assign rows_per_step = (quo == '0) ? HEIGHT_W'(1) : quo;
  assign step_inc      = {1'b0, step_cnt} + (HEIGHT_W + 1)'(1);

  assign dec_now        = wide || (step_inc >= {1'b0, rows_per_step});
  assign dec_amt        = (wide && shrink4) ? WIDTH_W'(SHRINK_WIDE) : WIDTH_W'(SHRINK_NARROW);
  assign width_next     = dec_now ? (row_width - dec_amt) : row_width;
  assign width_pos_next = !dec_now || (row_width > dec_amt);
  assign cnt_inc        = row_cnt + COUNT_W'(1);

  assign has_span = (row_width != '0) && (HEIGHT_W'(row_cnt) <= hgt)
                    && (row_cnt < COUNT_W'(SPAN_LIMIT));
  assign next_has = width_pos_next && (HEIGHT_W'(cnt_inc) <= hgt)
                    && (cnt_inc < COUNT_W'(SPAN_LIMIT));

  // Center the span on the base: the width difference is always even.
  assign w_diff = base_w - row_width;
  assign xs     = {base_x[COORD_BITS-1], base_x} + CW'(w_diff[WIDTH_W-1:1]);
  assign xe     = xs + CW'(row_width) - CW'(1);

  always_comb begin
    status          = '0;
    status.div_done = cmd.div_step && (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    status.has_span = has_span;
    status.last     = !next_has;
    status.out_free = !span_valid || !span_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_x    <= pos_x;
      base_w    <= w_sat;
      hgt       <= height;
      outl      <= outline;
      col_r     <= color_r;
      col_g     <= color_g;
      col_b     <= color_b;
      wide      <= (HEIGHT_W'(w_sat) >= height);
      shrink4   <= ((HEIGHT_W + 1)'(w_sat) >
                    ((HEIGHT_W + 1)'(height) + (HEIGHT_W + 1)'(WIDE_MARGIN)));
      row_width <= w_sat;
      row_y     <= {pos_y[COORD_BITS-1], pos_y} + CW'(height);
      row_cnt   <= '0;
      step_cnt  <= '0;
      divisor   <= (half_w == '0) ? STEP_W'(1) : half_w;
      rem       <= '0;
      quo       <= height;
      div_cnt   <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      quo     <= {quo[HEIGHT_W-2:0], ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end else if (cmd.emit) begin
      row_width <= width_next;
      row_y     <= row_y - CW'(1);
      row_cnt   <= cnt_inc;
      if (!wide) begin
        step_cnt <= dec_now ? '0 : step_inc[HEIGHT_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      span_x         <= xs;
      span_end_x     <= xe;
      span_y         <= row_y;
      span_len       <= row_width;
      endpoints_only <= outl && (row_cnt != '0);
      out_r          <= col_r;
      out_g          <= col_g;
      out_b          <= col_b;
      last_span      <= !next_has;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (cmd.emit) begin
      span_valid <= 1'b1;
    end else if (!span_stall) begin
      span_valid <= 1'b0;
    end
  end

  a_emit_has_span: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> has_span)
    else $error("span emitted from an empty row state");

  // After the final span the row width may wrap, so only a non-final beat is checked.
  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !status.last) |=> has_span)
    else $error("last flag disagrees with the next row state");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> (span_len != '0))
    else $error("zero-length span on the output");

endmodule
